// File: hw/rtl/lrc_pkg.sv
// Shared types and constants of the LRU row cache.
package lrc_pkg;

  localparam int ENTRIES   = 512;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int RANK_W    = IDX_W;
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int KEY_W     = 31;
  localparam int WORD_W    = 32;
  localparam int CAP_W     = 10;
  localparam int OCC_W     = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(500);

  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;
  localparam logic [1:0] FUNC_CLEAR  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TRACKING = CFG_IDX_W'(1);

  typedef struct packed {
    logic              valid;
    logic [RANK_W-1:0] rank;
    logic [KEY_W-1:0]  key;
  } tag_t;

  typedef struct packed {
    logic [WORD_W-1:0] payload;
    logic [WORD_W-1:0] color;
  } dat_t;

  typedef struct packed {
    logic [IDX_W-1:0] rd_addr;
    logic             tag_we;
    logic [IDX_W-1:0] tag_waddr;
    tag_t             tag_wdata;
    logic             dat_we;
    logic [IDX_W-1:0] dat_waddr;
    dat_t             dat_wdata;
  } store_req_t;

  typedef struct packed {
    tag_t tag;
    dat_t dat;
  } store_rsp_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [KEY_W-1:0]  key;
    logic [WORD_W-1:0] payload;
    logic [WORD_W-1:0] color;
  } op_t;

  typedef struct packed {
    logic              hit;
    logic [WORD_W-1:0] payload;
    logic [WORD_W-1:0] color;
    logic [OCC_W-1:0]  occupancy;
    logic [WORD_W-1:0] hits;
    logic [WORD_W-1:0] misses;
  } res_t;

endpackage

// File: hw/rtl/lrc_store.sv
// Entry storage: tag memory (valid, rank, key) and data memory (payload, colour).
module lrc_store (
  input  logic               clk,
  input  lrc_pkg::store_req_t req,
  output lrc_pkg::store_rsp_t rsp
);

  lrc_pkg::tag_t tag_mem [lrc_pkg::ENTRIES];
  lrc_pkg::dat_t dat_mem [lrc_pkg::ENTRIES];

  always_ff @(posedge clk) begin
    if (req.tag_we) begin
      tag_mem[req.tag_waddr] <= req.tag_wdata;
    end
    if (req.dat_we) begin
      dat_mem[req.dat_waddr] <= req.dat_wdata;
    end
    rsp <= '{tag: tag_mem[req.rd_addr], dat: dat_mem[req.rd_addr]};
  end

endmodule

// File: hw/rtl/lrc_seq.sv
// Sequencer: sweeps the entries through one shared compare/update path.
module lrc_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  lrc_pkg::op_t                  op,
  input  logic [lrc_pkg::CAP_W-1:0]     capacity,
  input  logic                          tracking,
  output logic                          idle,
  input  logic                          out_free,
  output logic                          res_valid,
  output lrc_pkg::res_t                 res,
  output lrc_pkg::store_req_t           req,
  input  lrc_pkg::store_rsp_t           rsp
);

  typedef enum logic [4:0] {
    ST_INIT = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_UPD  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    MODE_TOUCH,
    MODE_DROP,
    MODE_NEW,
    MODE_CLR
  } mode_t;

  localparam int IW = lrc_pkg::IDX_W;

  state_t                       state;
  mode_t                        mode;
  lrc_pkg::op_t                 cur;
  logic [IW:0]                  cnt;
  logic                         pend;
  logic [IW-1:0]                pidx;
  logic                         found;
  logic [IW-1:0]                slot;
  logic [lrc_pkg::RANK_W-1:0]   slot_rank;
  logic                         free_found;
  logic [IW-1:0]                free_slot;
  logic [IW-1:0]                lru_slot;
  logic                         evict;
  logic [IW-1:0]                new_slot;
  logic [lrc_pkg::CNT_W-1:0]    vc;
  logic [lrc_pkg::WORD_W-1:0]   hits;
  logic [lrc_pkg::WORD_W-1:0]   misses;
  logic                         hit;
  logic [lrc_pkg::WORD_W-1:0]   hit_payload;
  logic [lrc_pkg::WORD_W-1:0]   hit_color;

  logic                         issue;
  logic                         pass_end;
  logic                         sweeping;
  logic [lrc_pkg::CAP_W-1:0]    cap_clamp;
  logic                         evict_c;
  logic [IW-1:0]                new_slot_c;
  logic                         have_slot_c;
  lrc_pkg::tag_t                t;
  lrc_pkg::tag_t                nt;

  assign t        = rsp.tag;
  assign sweeping = (state == ST_SCAN) || (state == ST_UPD) || (state == ST_INIT);
  assign issue    = sweeping && (cnt < (IW + 1)'(lrc_pkg::ENTRIES));
  assign pass_end = sweeping && !issue && !pend;

  always_comb begin
    cap_clamp = capacity;
    if (capacity == '0) begin
      cap_clamp = lrc_pkg::CAP_W'(1);
    end else if (capacity > lrc_pkg::CAP_W'(lrc_pkg::ENTRIES)) begin
      cap_clamp = lrc_pkg::CAP_W'(lrc_pkg::ENTRIES);
    end
  end

  always_comb begin
    evict_c     = (vc >= lrc_pkg::CNT_W'(cap_clamp)) && (vc != '0);
    new_slot_c  = free_slot;
    if (evict_c && !(free_found && (free_slot < lru_slot))) begin
      new_slot_c = lru_slot;
    end
    have_slot_c = evict_c || free_found;
  end

  // read-modify-write of one tag per cycle
  always_comb begin
    nt = t;
    if (state == ST_INIT) begin
      nt = '0;
    end else begin
      case (mode)
        MODE_TOUCH: begin
          if (pidx == slot) begin
            nt.rank = '0;
          end else if (t.valid && (t.rank < slot_rank)) begin
            nt.rank = t.rank + lrc_pkg::RANK_W'(1);
          end
        end
        MODE_DROP: begin
          if (pidx == slot) begin
            nt.valid = 1'b0;
          end else if (t.valid && (t.rank > slot_rank)) begin
            nt.rank = t.rank - lrc_pkg::RANK_W'(1);
          end
        end
        MODE_NEW: begin
          // all survivors are younger than the evicted entry, so each ages by one
          if (pidx == new_slot) begin
            nt.valid = 1'b1;
            nt.rank  = '0;
            nt.key   = cur.key;
          end else if (evict && (pidx == lru_slot)) begin
            nt.valid = 1'b0;
          end else if (t.valid) begin
            nt.rank = t.rank + lrc_pkg::RANK_W'(1);
          end
        end
        MODE_CLR: begin
          nt = '0;
        end
        default: begin
          nt = t;
        end
      endcase
    end
  end

  always_comb begin
    req.rd_addr       = cnt[IW-1:0];
    req.tag_we        = pend && ((state == ST_UPD) || (state == ST_INIT));
    req.tag_waddr     = pidx;
    req.tag_wdata     = nt;
    req.dat_we        = pass_end && (state == ST_SCAN) && (cur.func == lrc_pkg::FUNC_INSERT)
                        && (found || have_slot_c);
    req.dat_waddr     = found ? slot : new_slot_c;
    req.dat_wdata     = '{payload: cur.payload, color: cur.color};
  end

  assign idle      = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  always_comb begin
    res.hit       = hit;
    res.payload   = hit ? hit_payload : '0;
    res.color     = hit ? hit_color : '0;
    res.occupancy = lrc_pkg::OCC_W'(vc);
    res.hits      = hits;
    res.misses    = misses;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_INIT;
      cnt    <= '0;
      pend   <= 1'b0;
      vc     <= '0;
      hits   <= '0;
      misses <= '0;
      hit    <= 1'b0;
      mode   <= MODE_CLR;
    end else begin
      pend <= issue;
      pidx <= cnt[IW-1:0];
      if (issue) begin
        cnt <= cnt + (IW + 1)'(1);
      end
      case (state)
        ST_INIT: begin
          if (pass_end) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            cur        <= op;
            cnt        <= '0;
            found      <= 1'b0;
            free_found <= 1'b0;
            lru_slot   <= '0;
            free_slot  <= '0;
            hit        <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (pend) begin
            if (t.valid && (t.key == cur.key) && !found) begin
              found       <= 1'b1;
              slot        <= pidx;
              slot_rank   <= t.rank;
              hit_payload <= rsp.dat.payload;
              hit_color   <= rsp.dat.color;
            end
            if (!t.valid && !free_found) begin
              free_found <= 1'b1;
              free_slot  <= pidx;
            end
            if (t.valid && (lrc_pkg::CNT_W'(t.rank) == vc - lrc_pkg::CNT_W'(1))) begin
              lru_slot <= pidx;
            end
          end
          if (pass_end) begin
            cnt   <= '0;
            case (cur.func)
              lrc_pkg::FUNC_LOOKUP: begin
                if (found) begin
                  hit   <= 1'b1;
                  mode  <= MODE_TOUCH;
                  state <= ST_UPD;
                  if (tracking && (hits != '1)) begin
                    hits <= hits + lrc_pkg::WORD_W'(1);
                  end
                end else begin
                  state <= ST_DONE;
                  if (tracking && (misses != '1)) begin
                    misses <= misses + lrc_pkg::WORD_W'(1);
                  end
                end
              end
              lrc_pkg::FUNC_INSERT: begin
                if (found) begin
                  mode  <= MODE_TOUCH;
                  state <= ST_UPD;
                end else if (have_slot_c) begin
                  mode     <= MODE_NEW;
                  evict    <= evict_c;
                  new_slot <= new_slot_c;
                  state    <= ST_UPD;
                  if (!evict_c) begin
                    vc <= vc + lrc_pkg::CNT_W'(1);
                  end
                end else begin
                  state <= ST_DONE;
                end
              end
              lrc_pkg::FUNC_REMOVE: begin
                if (found) begin
                  mode  <= MODE_DROP;
                  state <= ST_UPD;
                  if (vc != '0) begin
                    vc <= vc - lrc_pkg::CNT_W'(1);
                  end
                end else begin
                  state <= ST_DONE;
                end
              end
              default: begin
                mode   <= MODE_CLR;
                state  <= ST_UPD;
                vc     <= '0;
                hits   <= '0;
                misses <= '0;
              end
            endcase
          end
        end
        ST_UPD: begin
          if (pass_end) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_INIT;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/lru_row_cache_unit.sv
// LRU row cache: fully associative, 512 entries, least-recently-used replacement.
//
// Input stream s_*: one operation per transfer. s_tuser holds func (lookup,
// insert, remove, clear); s_tdata holds row_key, row_payload, row_color.
// Output stream m_*: one result per operation. m_tuser holds hit; m_tdata
// holds payload_out, color_out, occupancy, hit_count, miss_count.
// Config channel cfg_*: index 0 capacity, index 1 tracking_enabled; always ready.
// The user must write it only while no operation is in flight; the block does not enforce this.
//
// Each operation sweeps all ENTRIES tags through one compare/update path, one
// entry per cycle: a search pass, and for hits, inserts, removes and clears a
// rank update pass; misses and absent removes end after the search pass.
// s_tready stays low until the sequencer is idle again, so the next transfer
// is taken only once the last operation's passes are done.
// After reset a clearing pass empties the tag memory before the first transfer
// is taken. A stalled result sits in the output register; the next operation
// may be accepted meanwhile, and its result waits in the sequencer until the
// register frees.
module lru_row_cache_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // row_key[30:0], row_payload[62:31], row_color[94:63], pad
  input  logic [1:0]   s_tuser,   // func[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata,   // payload_out[31:0], color_out[63:32], occupancy[73:64],
                                  // hit_count[105:74], miss_count[137:106], pad
  output logic [0:0]   m_tuser,   // hit[0]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [lrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lrc_pkg::CAP_W-1:0]     cfg_data
);

  logic [lrc_pkg::CAP_W-1:0] capacity;
  logic                      tracking;
  lrc_pkg::op_t              op;
  lrc_pkg::res_t             res;
  lrc_pkg::store_req_t       req;
  lrc_pkg::store_rsp_t       rsp;
  logic                      idle;
  logic                      res_valid;
  logic                      out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lrc_pkg::CAPACITY_RESET;
      tracking <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        lrc_pkg::REG_CAPACITY: capacity <= cfg_data;
        lrc_pkg::REG_TRACKING: tracking <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign op.func    = s_tuser;
  assign op.key     = s_tdata[30:0];
  assign op.payload = s_tdata[62:31];
  assign op.color   = s_tdata[94:63];

  assign s_tready = idle;
  assign out_free = !m_tvalid || m_tready;

  lrc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (s_tvalid),
    .op        (op),
    .capacity  (capacity),
    .tracking  (tracking),
    .idle      (idle),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .req       (req),
    .rsp       (rsp)
  );

  lrc_store u_store (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      m_tuser <= res.hit;
      m_tdata <= {6'd0, res.misses, res.hits, res.occupancy, res.color, res.payload};
    end
  end

endmodule

// File: hw/rtl/lrc_checker.sv
// Port-level checks on the LRU row cache, bound to the top level.
module lrc_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [143:0] m_tdata,
  input logic [0:0]   m_tuser
);

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[63:0] == 64'd0)
    else $error("payload or colour non-zero without a hit");

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[73:64] <= 10'd512)
    else $error("occupancy above entry count");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second operation taken while busy");

endmodule

bind lru_row_cache_unit lrc_checker u_lrc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: sim/tb.sv
// Self-checking testbench for the LRU row cache: directed and random traffic against a predictor.
`timescale 1ns / 1ps

module tb;

  typedef enum logic [1:0] {K_OP, K_CFG, K_PAUSE} kind_e;

  typedef struct {
    kind_e                         kind;
    lrc_pkg::op_t                  op;
    logic [lrc_pkg::CFG_IDX_W-1:0] idx;
    logic [lrc_pkg::CAP_W-1:0]     data;
  } item_t;

  localparam int WATCHDOG = 20000;
  localparam int DRAIN    = 2 * lrc_pkg::ENTRIES + 40;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [95:0]  s_tdata = '0;
  logic [1:0]   s_tuser = lrc_pkg::FUNC_LOOKUP;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [143:0] m_tdata;
  logic [0:0]   m_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [lrc_pkg::CFG_IDX_W-1:0] cfg_index = lrc_pkg::REG_CAPACITY;
  logic [lrc_pkg::CAP_W-1:0]     cfg_data = '0;

  lru_row_cache_unit u_top (.*);

  always #6 clk = ~clk;

  // cache image kept by the predictor
  logic [lrc_pkg::KEY_W-1:0]  img_key   [lrc_pkg::ENTRIES];
  logic                       img_valid [lrc_pkg::ENTRIES];
  logic [lrc_pkg::WORD_W-1:0] img_pay   [lrc_pkg::ENTRIES];
  logic [lrc_pkg::WORD_W-1:0] img_col   [lrc_pkg::ENTRIES];
  int unsigned                img_rank  [lrc_pkg::ENTRIES];
  int unsigned                img_count = 0;
  logic [lrc_pkg::WORD_W-1:0] img_hits = '0, img_misses = '0;
  logic [lrc_pkg::CAP_W-1:0]  reg_cap = lrc_pkg::CAPACITY_RESET;
  logic                       reg_track = 1'b1;

  item_t          pending[$];
  lrc_pkg::res_t  expected_res[$];
  int             errors = 0;
  bit             burst = 1'b0;

  function automatic int find_row(logic [lrc_pkg::KEY_W-1:0] k);
    for (int i = 0; i < lrc_pkg::ENTRIES; i++)
      if (img_valid[i] && img_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void make_newest(int s, int unsigned old);
    for (int i = 0; i < lrc_pkg::ENTRIES; i++)
      if (img_valid[i] && i != s && img_rank[i] < old) img_rank[i]++;
    img_rank[s] = 0;
  endfunction

  function automatic void drop_row(int s);
    int unsigned r;
    r = img_rank[s];
    img_valid[s] = 1'b0;
    for (int i = 0; i < lrc_pkg::ENTRIES; i++)
      if (img_valid[i] && img_rank[i] > r) img_rank[i]--;
    if (img_count > 0) img_count--;
  endfunction

  function automatic logic [lrc_pkg::WORD_W-1:0] sat_inc(logic [lrc_pkg::WORD_W-1:0] v);
    return (v == '1) ? v : v + lrc_pkg::WORD_W'(1);
  endfunction

  function automatic lrc_pkg::res_t cache_result(lrc_pkg::op_t op);
    lrc_pkg::res_t r;
    int s, i;
    int unsigned cap;
    r = '0;
    cap = reg_cap;
    if (cap == 0) cap = 1;
    if (cap > lrc_pkg::ENTRIES) cap = lrc_pkg::ENTRIES;
    s = find_row(op.key);
    case (op.func)
      lrc_pkg::FUNC_LOOKUP: begin
        if (s >= 0) begin
          r.hit = 1'b1;
          r.payload = img_pay[s];
          r.color = img_col[s];
          make_newest(s, img_rank[s]);
          if (reg_track) img_hits = sat_inc(img_hits);
        end else if (reg_track) begin
          img_misses = sat_inc(img_misses);
        end
      end
      lrc_pkg::FUNC_INSERT: begin
        if (s >= 0) begin
          img_pay[s] = op.payload;
          img_col[s] = op.color;
          make_newest(s, img_rank[s]);
        end else begin
          if (img_count >= cap && img_count > 0) begin
            for (i = 0; i < lrc_pkg::ENTRIES; i++)
              if (img_valid[i] && img_rank[i] == img_count - 1) break;
            if (i < lrc_pkg::ENTRIES) drop_row(i);
          end
          for (i = 0; i < lrc_pkg::ENTRIES; i++)
            if (!img_valid[i]) break;
          if (i < lrc_pkg::ENTRIES) begin
            img_valid[i] = 1'b1;
            img_key[i] = op.key;
            img_pay[i] = op.payload;
            img_col[i] = op.color;
            img_count++;
            make_newest(i, img_count);
          end
        end
      end
      lrc_pkg::FUNC_REMOVE: if (s >= 0) drop_row(s);
      default: begin
        for (i = 0; i < lrc_pkg::ENTRIES; i++) img_valid[i] = 1'b0;
        img_count = 0;
        img_hits = '0;
        img_misses = '0;
      end
    endcase
    r.occupancy = img_count[lrc_pkg::OCC_W-1:0];
    r.hits = img_hits;
    r.misses = img_misses;
    return r;
  endfunction

  // handshakes seen at the last rising edge
  logic s_fire = 1'b0, cfg_fire = 1'b0, m_fire = 1'b0;
  int   quiet = 0;

  always @(posedge clk) begin
    lrc_pkg::res_t got, want;
    s_fire <= s_tvalid & s_tready;
    cfg_fire <= cfg_valid & cfg_ready;
    m_fire <= m_tvalid & m_tready;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == lrc_pkg::REG_CAPACITY) reg_cap = cfg_data;
        else if (cfg_index == lrc_pkg::REG_TRACKING) reg_track = cfg_data[0];
      end
      if (s_tvalid && s_tready)
        expected_res.insert(expected_res.size(),
                            cache_result(lrc_pkg::op_t'{s_tuser, s_tdata[30:0],
                                                        s_tdata[62:31], s_tdata[94:63]}));
      if (m_tvalid && m_tready) begin
        got.hit = m_tuser[0];
        got.payload = m_tdata[31:0];
        got.color = m_tdata[63:32];
        got.occupancy = m_tdata[73:64];
        got.hits = m_tdata[105:74];
        got.misses = m_tdata[137:106];
        if (expected_res.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          want = expected_res.pop_front();
          if (got.hit != want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, got.hit); errors++;
          end
          if (got.payload != want.payload) begin
            $error("payload_out: expected %h, got %h", want.payload, got.payload); errors++;
          end
          if (got.color != want.color) begin
            $error("color_out: expected %h, got %h", want.color, got.color); errors++;
          end
          if (got.occupancy != want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
            errors++;
          end
          if (got.hits != want.hits) begin
            $error("hit_count: expected %0d, got %0d", want.hits, got.hits); errors++;
          end
          if (got.misses != want.misses) begin
            $error("miss_count: expected %0d, got %0d", want.misses, got.misses); errors++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else if (++quiet >= WATCHDOG) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // sender and config writer
  bit s_busy = 1'b0, cfg_busy = 1'b0;
  int gap = 0, settle = 0;

  always @(negedge clk) begin
    item_t it;
    if (!rst) begin
      if (s_fire) s_busy = 1'b0;
      if (cfg_fire) cfg_busy = 1'b0;
      settle = (expected_res.size() == 0) ? settle + 1 : 0;
      if (!s_busy && !cfg_busy && pending.size() != 0) begin
        it = pending[0];
        if (it.kind == K_OP) begin
          if (gap > 0) gap--;
          else begin
            void'(pending.pop_front());
            s_busy = 1'b1;
            s_tuser <= it.op.func;
            s_tdata <= {1'b0, it.op.color, it.op.payload, it.op.key};
            gap = burst ? 0 : $urandom_range(0, 18);
          end
        end else if (settle > 8) begin
          void'(pending.pop_front());
          if (it.kind == K_CFG) begin
            cfg_busy = 1'b1;
            cfg_index <= it.idx;
            cfg_data <= it.data;
          end
        end
      end
      s_tvalid <= s_busy;
      cfg_valid <= cfg_busy;
    end
  end

  // result receiver with random stalls
  int stall = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (m_fire) stall = burst ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else m_tready <= 1'b1;
    end
  end

  logic [lrc_pkg::KEY_W-1:0] key_pool[12];

  function automatic void add_op(logic [1:0] f, logic [lrc_pkg::KEY_W-1:0] k,
                                 logic [lrc_pkg::WORD_W-1:0] p,
                                 logic [lrc_pkg::WORD_W-1:0] c);
    item_t it;
    it.kind = K_OP;
    it.op = lrc_pkg::op_t'{f, k, p, c};
    it.idx = lrc_pkg::REG_CAPACITY;
    it.data = '0;
    pending.insert(pending.size(), it);
  endfunction

  function automatic void add_cfg(logic [lrc_pkg::CFG_IDX_W-1:0] idx,
                                  logic [lrc_pkg::CAP_W-1:0] d);
    item_t it;
    it.kind = K_CFG;
    it.op = '0;
    it.idx = idx;
    it.data = d;
    pending.insert(pending.size(), it);
  endfunction

  function automatic void add_pause();
    item_t it;
    it = '{K_PAUSE, '0, lrc_pkg::REG_CAPACITY, '0};
    pending.insert(pending.size(), it);
  endfunction

  function automatic logic [lrc_pkg::WORD_W-1:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [lrc_pkg::KEY_W-1:0] rnd_key();
    return ($urandom_range(0, 9) == 0) ? lrc_pkg::KEY_W'($urandom)
                                       : key_pool[$urandom_range(0, 11)];
  endfunction

  initial begin
    int n, r;
    logic [1:0] f;
    for (int i = 0; i < lrc_pkg::ENTRIES; i++) begin
      img_valid[i] = 1'b0; img_key[i] = '0; img_pay[i] = '0; img_col[i] = '0; img_rank[i] = 0;
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 12; i++) key_pool[i] = lrc_pkg::KEY_W'($urandom);

    // directed: extremes, every operation, overwrite, absent remove, eviction
    add_op(lrc_pkg::FUNC_LOOKUP, '0, '0, '0);
    add_op(lrc_pkg::FUNC_INSERT, '0, '1, '1);
    add_op(lrc_pkg::FUNC_INSERT, '1, 32'h5555_5555, 32'hAAAA_AAAA);
    add_op(lrc_pkg::FUNC_LOOKUP, '1, '0, '0);
    add_op(lrc_pkg::FUNC_LOOKUP, '0, '0, '0);
    add_op(lrc_pkg::FUNC_INSERT, '1, 32'hAAAA_AAAA, 32'h5555_5555);
    add_op(lrc_pkg::FUNC_LOOKUP, '1, '1, '1);
    add_op(lrc_pkg::FUNC_REMOVE, 31'h1234_5678, '0, '0);
    add_op(lrc_pkg::FUNC_REMOVE, '0, '0, '0);
    add_op(lrc_pkg::FUNC_LOOKUP, '0, '0, '0);
    add_op(lrc_pkg::FUNC_INSERT, 31'h2AAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
    add_pause();
    add_cfg(lrc_pkg::REG_CAPACITY, 10'd1);          // lowered below occupancy
    add_op(lrc_pkg::FUNC_LOOKUP, '1, '0, '0);
    add_op(lrc_pkg::FUNC_INSERT, 31'h5555_5555, 32'h1, 32'h2);
    add_op(lrc_pkg::FUNC_INSERT, 31'h0000_0007, 32'h3, 32'h4);
    add_pause();
    add_cfg(lrc_pkg::REG_TRACKING, 10'd0);
    add_op(lrc_pkg::FUNC_LOOKUP, 31'h0000_0007, '0, '0);
    add_op(lrc_pkg::FUNC_LOOKUP, 31'h0000_0008, '0, '0);
    add_op(lrc_pkg::FUNC_CLEAR, '0, '0, '0);
    add_op(lrc_pkg::FUNC_LOOKUP, 31'h0000_0007, '0, '0);
    add_pause();
    add_cfg(lrc_pkg::REG_CAPACITY, 10'd0);
    add_cfg(lrc_pkg::REG_TRACKING, 10'd1);
    add_op(lrc_pkg::FUNC_INSERT, 31'h1, 32'h11, 32'h22);
    add_op(lrc_pkg::FUNC_INSERT, 31'h2, 32'h33, 32'h44);
    add_op(lrc_pkg::FUNC_LOOKUP, 31'h1, '0, '0);
    add_op(lrc_pkg::FUNC_LOOKUP, 31'h2, '0, '0);

    // random phases across register settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: n = 1023;
        1: n = 2;
        2: n = 512;
        3: n = 3;
        4: n = 0;
        5: n = 6;
        6: n = 1;
        default: n = $urandom_range(1, 1023);
      endcase
      add_pause();
      add_cfg(lrc_pkg::REG_CAPACITY, n[lrc_pkg::CAP_W-1:0]);
      add_cfg(lrc_pkg::REG_TRACKING, lrc_pkg::CAP_W'(ph % 3 != 1));
      for (int k = 0; k < 96; k++) begin
        r = $urandom_range(0, 99);
        f = (r < 40) ? lrc_pkg::FUNC_LOOKUP :
            (r < 75) ? lrc_pkg::FUNC_INSERT :
            (r < 96) ? lrc_pkg::FUNC_REMOVE : lrc_pkg::FUNC_CLEAR;
        add_op(f, rnd_key(), rnd_word(), rnd_word());
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    fork
      forever begin
        repeat ($urandom_range(20000, 60000)) @(posedge clk);
        burst = ~burst;
      end
    join_none
    wait (pending.size() == 0 && !s_busy && !cfg_busy);
    wait (expected_res.size() == 0);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && expected_res.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
